// ----- hw/rtl/ssa_pkg.sv -----
`default_nettype none

package ssa_pkg;

   localparam int COUNT_BITS = 24;
   localparam int FRAC_BITS  = 8;

   localparam int SAMPLE_W = 16;
   localparam int TOTAL_W  = 24;
   localparam int SUM_W    = 40;
   localparam int SQ_W     = 56;
   localparam int FIX_W    = 24;

   localparam int MEAN_DIVIDEND_W = SUM_W + FRAC_BITS;
   localparam int PROD_A_W        = COUNT_BITS + SQ_W;
   localparam int PROD_B_W        = 2 * SUM_W;
   localparam int NUM_W           = (PROD_A_W > PROD_B_W) ? PROD_A_W : PROD_B_W;
   localparam int DEN_W           = 2 * COUNT_BITS;
   localparam int DIVIDEND_W      = NUM_W + 2 * FRAC_BITS;
   localparam int QUO_W           = 64;
   localparam int ROOT_W          = QUO_W / 2;
   localparam int ALU_W0          = (NUM_W > DEN_W + 1) ? NUM_W : DEN_W + 1;
   localparam int ALU_W           = (ALU_W0 > QUO_W) ? ALU_W0 : QUO_W;
   localparam int STEP_W          = $clog2(DIVIDEND_W);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [SAMPLE_W-1:0]   MIN_EMPTY = '1;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_SINGLE    = 2'd1,
      STATUS_EMPTY     = 2'd2,
      STATUS_SATURATED = 2'd3
   } status_type;

   typedef enum logic {
      TOP_IDLE,
      TOP_CALC
   } top_state_type;

   typedef enum logic [3:0] {
      ENG_IDLE,
      ENG_MEAN,
      ENG_MUL_D,
      ENG_MUL_A,
      ENG_MUL_B,
      ENG_DIFF,
      ENG_DIV,
      ENG_SQRT,
      ENG_DONE
   } eng_state_type;

   typedef struct packed {
      logic start;
      logic ack;
   } ssa_ctrl_type;

   typedef struct packed {
      logic             done;
      logic [FIX_W-1:0] mean;
      logic [FIX_W-1:0] dev;
   } ssa_report_type;

endpackage

`default_nettype wire

// ----- hw/rtl/sample_statistics_accumulator.sv -----
// Sample word: accepted one per cycle, back to back, while no finish word is in progress.
// Finish word: the engine runs a mean division, three products, a difference, a division
// and a square root; an empty set skips all of them and a single sample stops after the mean;
// input stalls until the report is loaded.
// One shared adder/subtractor resolves one quotient, product or root bit per cycle.
// Reset: synchronous, clears the accumulators, the sequencer and rsp_valid.
`default_nettype none

module sample_statistics_accumulator (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_valid,
   output logic                            req_stall,
   input  wire                             req_func,
   input  wire  [ssa_pkg::SAMPLE_W-1:0]    req_sample,
   output logic                            rsp_valid,
   input  wire                             rsp_stall,
   output logic [1:0]                      rsp_status,
   output logic [ssa_pkg::TOTAL_W-1:0]     rsp_sample_total,
   output logic [ssa_pkg::SAMPLE_W-1:0]    rsp_smallest,
   output logic [ssa_pkg::SAMPLE_W-1:0]    rsp_largest,
   output logic [ssa_pkg::SUM_W-1:0]       rsp_value_sum,
   output logic [ssa_pkg::FIX_W-1:0]       rsp_mean_fixed,
   output logic [ssa_pkg::FIX_W-1:0]       rsp_deviation_fixed
);
   import ssa_pkg::*;

   top_state_type         state_ff, state_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [SQ_W-1:0]       square_ff, square_in;
   logic [SAMPLE_W-1:0]   min_ff, min_in;
   logic [SAMPLE_W-1:0]   max_ff, max_in;
   logic                  overflow_ff, overflow_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   status_type            rsp_status_ff;
   logic [TOTAL_W-1:0]    rsp_total_ff;
   logic [SAMPLE_W-1:0]   rsp_min_ff, rsp_max_ff;
   logic [SUM_W-1:0]      rsp_sum_ff;
   logic [FIX_W-1:0]      rsp_mean_ff, rsp_dev_ff;

   logic                  take, out_free, load;
   logic [2*SAMPLE_W-1:0] sample_sq;
   status_type            status_now;
   ssa_ctrl_type          ctrl;
   ssa_report_type        report;

   ssa_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl),
      .count_value  (count_ff),
      .sum_value    (sum_ff),
      .square_value (square_ff),
      .report       (report)
   );

   assign req_stall  = (state_ff != TOP_IDLE);
   assign take       = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign load       = (state_ff == TOP_CALC) && report.done && out_free;
   assign ctrl.start = take && req_func;
   assign ctrl.ack   = load;
   assign sample_sq  = req_sample * req_sample;

   always_comb begin
      priority if (count_ff == '0) begin
         status_now = STATUS_EMPTY;
      end else if (overflow_ff) begin
         status_now = STATUS_SATURATED;
      end else if (count_ff == COUNT_BITS'(1)) begin
         status_now = STATUS_SINGLE;
      end else begin
         status_now = STATUS_OK;
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      square_in    = square_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      overflow_in  = overflow_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         TOP_IDLE: begin
            if (take && req_func) begin
               state_in = TOP_CALC;
            end else if (take) begin
               // drop the sample once the count is pinned
               if (count_ff == COUNT_MAX) begin
                  overflow_in = 1'b1;
               end else begin
                  count_in  = count_ff + 1'b1;
                  sum_in    = sum_ff + SUM_W'(req_sample);
                  square_in = square_ff + SQ_W'(sample_sq);
                  if (req_sample < min_ff) min_in = req_sample;
                  if (req_sample > max_ff) max_in = req_sample;
               end
            end
         end
         TOP_CALC: begin
            if (load) begin
               state_in     = TOP_IDLE;
               rsp_valid_in = 1'b1;
               count_in     = '0;
               sum_in       = '0;
               square_in    = '0;
               min_in       = MIN_EMPTY;
               max_in       = '0;
               overflow_in  = 1'b0;
            end
         end
         default: begin
            state_in = TOP_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= TOP_IDLE;
         count_ff     <= '0;
         sum_ff       <= '0;
         square_ff    <= '0;
         min_ff       <= MIN_EMPTY;
         max_ff       <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         square_ff    <= square_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_status_ff <= status_now;
         rsp_total_ff  <= TOTAL_W'(count_ff);
         rsp_min_ff    <= min_ff;
         rsp_max_ff    <= max_ff;
         rsp_sum_ff    <= sum_ff;
         rsp_mean_ff   <= report.mean;
         rsp_dev_ff    <= report.dev;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_sample_total    = rsp_total_ff;
   assign rsp_smallest        = rsp_min_ff;
   assign rsp_largest         = rsp_max_ff;
   assign rsp_value_sum       = rsp_sum_ff;
   assign rsp_mean_fixed      = rsp_mean_ff;
   assign rsp_deviation_fixed = rsp_dev_ff;

   a_clear_after_load: assert property (@(posedge clock) disable iff (reset)
      load |=> count_ff == '0 && !overflow_ff && sum_ff == '0)
      else $error("accumulators not cleared after report");

   a_empty_report_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_EMPTY |->
         rsp_mean_fixed == '0 && rsp_deviation_fixed == '0)
      else $error("empty report carries nonzero statistics");

   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      count_ff != '0 |-> min_ff <= max_ff)
      else $error("minimum above maximum");

   a_idle_engine_quiet: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !report.done)
      else $error("engine reports while block idle");

endmodule

`default_nettype wire

// ----- hw/rtl/ssa_engine.sv -----
`default_nettype none

module ssa_engine (
   input  wire                             clock,
   input  wire                             reset,
   input  ssa_pkg::ssa_ctrl_type           ctrl,
   input  wire  [ssa_pkg::COUNT_BITS-1:0]  count_value,
   input  wire  [ssa_pkg::SUM_W-1:0]       sum_value,
   input  wire  [ssa_pkg::SQ_W-1:0]        square_value,
   output ssa_pkg::ssa_report_type         report
);
   import ssa_pkg::*;

   eng_state_type     state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [ALU_W-1:0]  acc_ff, acc_in;
   logic [ALU_W-1:0]  shf_ff, shf_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic              sticky_ff, sticky_in;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [FIX_W-1:0]  mean_ff, mean_in;
   logic [FIX_W-1:0]  dev_ff, dev_in;

   // shared adder/subtractor
   logic [ALU_W-1:0]  alu_a, alu_b, alu_res;
   logic              alu_sub, alu_cout;

   logic              last_step;
   logic [COUNT_BITS-1:0] count_less;
   logic [QUO_W-1:0]  quo_next;
   logic [QUO_W-1:0]  root_op;

   assign {alu_cout, alu_res} = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                                + (ALU_W+1)'(alu_sub);

   assign last_step  = (step_ff == '0);
   assign count_less = count_value - 1'b1;
   // quotient after this division step; saturate when bits fall off the top
   assign quo_next   = {quo_ff[QUO_W-2:0], alu_cout};
   assign root_op    = (sticky_ff || quo_ff[QUO_W-1]) ? '1 : quo_next;

   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b0;
      unique case (state_ff)
         ENG_MEAN: begin
            alu_a   = (acc_ff << 1) | ALU_W'(shf_ff[MEAN_DIVIDEND_W-1]);
            alu_b   = ALU_W'(count_value);
            alu_sub = 1'b1;
         end
         ENG_MUL_D: begin
            alu_a = acc_ff << 1;
            alu_b = shf_ff[COUNT_BITS-1] ? ALU_W'(count_less) : '0;
         end
         ENG_MUL_A: begin
            alu_a = acc_ff << 1;
            alu_b = shf_ff[COUNT_BITS-1] ? ALU_W'(square_value) : '0;
         end
         ENG_MUL_B: begin
            alu_a = acc_ff << 1;
            alu_b = shf_ff[SUM_W-1] ? ALU_W'(sum_value) : '0;
         end
         ENG_DIFF: begin
            alu_a   = ALU_W'(num_ff);
            alu_b   = acc_ff;
            alu_sub = 1'b1;
         end
         ENG_DIV: begin
            alu_a   = (acc_ff << 1) | ALU_W'(shf_ff[NUM_W-1]);
            alu_b   = ALU_W'(den_ff);
            alu_sub = 1'b1;
         end
         ENG_SQRT: begin
            alu_a   = acc_ff;
            alu_b   = shf_ff | ALU_W'(quo_ff);
            alu_sub = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff - 1'b1;
      acc_in    = acc_ff;
      shf_in    = shf_ff;
      quo_in    = quo_ff;
      sticky_in = sticky_ff;
      num_in    = num_ff;
      den_in    = den_ff;
      mean_in   = mean_ff;
      dev_in    = dev_ff;
      unique case (state_ff)
         ENG_IDLE: begin
            if (ctrl.start) begin
               mean_in = '0;
               dev_in  = '0;
               if (count_value == '0) begin
                  state_in = ENG_DONE;
               end else begin
                  state_in = ENG_MEAN;
                  acc_in   = '0;
                  shf_in   = ALU_W'(sum_value) << FRAC_BITS;
                  quo_in   = '0;
                  step_in  = STEP_W'(MEAN_DIVIDEND_W - 1);
               end
            end
         end
         ENG_MEAN: begin
            acc_in = alu_cout ? alu_res : alu_a;
            quo_in = quo_next;
            shf_in = shf_ff << 1;
            if (last_step) begin
               mean_in = (|quo_next[QUO_W-1:FIX_W]) ? '1 : quo_next[FIX_W-1:0];
               if (count_value == COUNT_BITS'(1)) begin
                  state_in = ENG_DONE;
               end else begin
                  state_in = ENG_MUL_D;
                  acc_in   = '0;
                  shf_in   = ALU_W'(count_value);
                  step_in  = STEP_W'(COUNT_BITS - 1);
               end
            end
         end
         ENG_MUL_D: begin
            acc_in = alu_res;
            shf_in = shf_ff << 1;
            if (last_step) begin
               den_in   = alu_res[DEN_W-1:0];
               state_in = ENG_MUL_A;
               acc_in   = '0;
               shf_in   = ALU_W'(count_value);
               step_in  = STEP_W'(COUNT_BITS - 1);
            end
         end
         ENG_MUL_A: begin
            acc_in = alu_res;
            shf_in = shf_ff << 1;
            if (last_step) begin
               num_in   = alu_res[NUM_W-1:0];
               state_in = ENG_MUL_B;
               acc_in   = '0;
               shf_in   = ALU_W'(sum_value);
               step_in  = STEP_W'(SUM_W - 1);
            end
         end
         ENG_MUL_B: begin
            acc_in = alu_res;
            shf_in = shf_ff << 1;
            if (last_step) begin
               state_in = ENG_DIFF;
            end
         end
         ENG_DIFF: begin
            // clamp a negative numerator to zero
            shf_in    = alu_cout ? alu_res : '0;
            acc_in    = '0;
            quo_in    = '0;
            sticky_in = 1'b0;
            step_in   = STEP_W'(DIVIDEND_W - 1);
            state_in  = ENG_DIV;
         end
         ENG_DIV: begin
            acc_in    = alu_cout ? alu_res : alu_a;
            quo_in    = quo_next;
            sticky_in = sticky_ff | quo_ff[QUO_W-1];
            shf_in    = shf_ff << 1;
            if (last_step) begin
               state_in = ENG_SQRT;
               acc_in   = ALU_W'(root_op);
               shf_in   = '0;
               quo_in   = QUO_W'(1) << (QUO_W - 2);
               step_in  = STEP_W'(ROOT_W - 1);
            end
         end
         ENG_SQRT: begin
            if (alu_cout) begin
               acc_in = alu_res;
               shf_in = (shf_ff >> 1) | ALU_W'(quo_ff);
            end else begin
               shf_in = shf_ff >> 1;
            end
            quo_in = quo_ff >> 2;
            if (last_step) begin
               dev_in   = (|shf_in[ALU_W-1:FIX_W]) ? '1 : shf_in[FIX_W-1:0];
               state_in = ENG_DONE;
            end
         end
         ENG_DONE: begin
            if (ctrl.ack) begin
               state_in = ENG_IDLE;
            end
         end
         default: begin
            state_in = ENG_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ENG_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff   <= step_in;
      acc_ff    <= acc_in;
      shf_ff    <= shf_in;
      quo_ff    <= quo_in;
      sticky_ff <= sticky_in;
      num_ff    <= num_in;
      den_ff    <= den_in;
      mean_ff   <= mean_in;
      dev_ff    <= dev_in;
   end

   assign report.done = (state_ff == ENG_DONE);
   assign report.mean = mean_ff;
   assign report.dev  = dev_ff;

   a_ack_only_when_done: assert property (@(posedge clock) disable iff (reset)
      ctrl.ack |-> state_ff == ENG_DONE)
      else $error("ack while engine not done");

   a_start_only_idle: assert property (@(posedge clock) disable iff (reset)
      ctrl.start |-> state_ff == ENG_IDLE)
      else $error("start while engine busy");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      state_ff == ENG_DONE && !ctrl.ack |=> state_ff == ENG_DONE && $stable(dev_ff))
      else $error("report lost before ack");

endmodule

`default_nettype wire
